// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vstk_pkg.sv -----
// Types and constants shared by the value stack and its storage cells.
package vstk_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Command codes of an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_MAX     = 3'd3,
        CMD_EXTRACT = 3'd4,
        CMD_REVERSE = 3'd5,
        CMD_CLEAR   = 3'd6
    } t_cmd;

    // Status codes of a result word.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain in the same cycle.
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH       = 3'd1,
        CELL_UP         = 3'd2,
        CELL_LOAD_SPAN  = 3'd3,
        CELL_ROTATE     = 3'd4,
        CELL_ROT_SHRINK = 3'd5,
        CELL_CLEAR      = 3'd6
    } t_cell_op;

    // Control bundle from the sequencer to the cells; head is the top cell's value.
    typedef struct packed {
        t_cell_op               op;
        logic [VALUE_W-1:0]     head;
    } t_cell_ctl;

endpackage

// ----- src/vstk_cell.sv -----
// One storage cell of the stack chain: a value, its occupied bit and its span bit.
module vstk_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vstk_pkg::t_cell_ctl          i_ctl,
    input  logic [vstk_pkg::VALUE_W-1:0] i_above_value,
    input  logic                         i_above_occ,
    input  logic [vstk_pkg::VALUE_W-1:0] i_below_value,
    input  logic                         i_below_occ,
    input  logic                         i_below_span,
    output logic [vstk_pkg::VALUE_W-1:0] o_value,
    output logic                         o_occ,
    output logic                         o_span
);

    logic [vstk_pkg::VALUE_W-1:0] r_value;
    logic [vstk_pkg::VALUE_W-1:0] n_value;
    logic                         r_occ;
    logic                         n_occ;
    logic                         r_span;
    logic                         n_span;

    // Next state of the cell. A rotation moves the head word to the last cell of the
    // span and every other spanned cell takes the word from the cell below it.
    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        n_span  = r_span;
        case (i_ctl.op)
            vstk_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            vstk_pkg::CELL_PUSH: begin
                n_value = i_above_value;
                n_occ   = i_above_occ;
            end
            vstk_pkg::CELL_UP: begin
                n_value = i_below_value;
                n_occ   = i_below_occ;
                n_span  = i_below_span;
            end
            vstk_pkg::CELL_LOAD_SPAN: begin
                n_span = r_occ;
            end
            vstk_pkg::CELL_ROTATE: begin
                if (r_span) begin
                    n_value = i_below_span ? i_below_value : i_ctl.head;
                end
            end
            vstk_pkg::CELL_ROT_SHRINK: begin
                if (r_span) begin
                    n_value = i_below_span ? i_below_value : i_ctl.head;
                end
                n_span = i_below_span;
            end
            vstk_pkg::CELL_CLEAR: begin
                n_occ  = 1'b0;
                n_span = 1'b0;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Stored word; it carries no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Occupancy and span bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_span <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_span <= n_span;
        end
    end

    assign o_value = r_value;
    assign o_occ   = r_occ;
    assign o_span  = r_span;

endmodule

// ----- src/value_stack_with_remove_and_max.sv -----
// Top level of the bounded value stack with remove, maximum, extract and reverse.
//
// A bounded LIFO of DEPTH words kept in a chain of cells, the top of the stack in the
// first cell. Each accepted command word gives exactly one result word, which is loaded
// into the result register as the block returns to idle for the next command word. Push,
// pop, clear, every command on an empty stack and a reverse of under two words need no
// rotation. Remove and read max rotate the occupied part of the chain by one cell per
// cycle past the comparators at the top cell, and extract max makes two such passes;
// reverse rotates a span of the chain that shrinks by one cell with each step. One
// command is worked on at a time; a new command word is taken while the previous result
// still waits, and a finished command then holds until the result register has been
// emptied.
module value_stack_with_remove_and_max #(
    parameter int unsigned DEPTH = vstk_pkg::DEPTH_DEFAULT,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vstk_pkg::CMD_W-1:0]    i_command,
    input  logic [vstk_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vstk_pkg::VALUE_W-1:0]  o_result_value,
    output logic [vstk_pkg::STATUS_W-1:0] o_status,
    output logic [CW-1:0]                 o_entry_count,
    output logic                          o_is_empty
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_REV    = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    vstk_pkg::t_cmd                r_cmd;
    vstk_pkg::t_cmd                n_cmd;
    logic [vstk_pkg::VALUE_W-1:0]  r_key;
    logic [vstk_pkg::VALUE_W-1:0]  n_key;
    logic [vstk_pkg::VALUE_W-1:0]  r_max;
    logic [vstk_pkg::VALUE_W-1:0]  n_max;
    logic [vstk_pkg::VALUE_W-1:0]  r_res;
    logic [vstk_pkg::VALUE_W-1:0]  n_res;
    vstk_pkg::t_status             r_stat;
    vstk_pkg::t_status             n_stat;
    logic                          r_found;
    logic                          n_found;
    logic                          r_pass2;
    logic                          n_pass2;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [CW-1:0]                 r_steps;
    logic [CW-1:0]                 n_steps;

    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [vstk_pkg::VALUE_W-1:0]  r_out_value;
    logic [vstk_pkg::STATUS_W-1:0] r_out_status;
    logic [CW-1:0]                 r_out_count;
    logic                          r_out_empty;
    logic                          w_out_load;

    vstk_pkg::t_cell_ctl           w_ctl;
    logic [vstk_pkg::VALUE_W-1:0]  w_value [DEPTH];
    logic [vstk_pkg::VALUE_W-1:0]  w_above_value [DEPTH];
    logic [vstk_pkg::VALUE_W-1:0]  w_below_value [DEPTH];
    logic [DEPTH-1:0]              w_occ;
    logic [DEPTH-1:0]              w_span;
    logic [DEPTH-1:0]              w_above_occ;
    logic [DEPTH-1:0]              w_below_occ;
    logic [DEPTH-1:0]              w_below_span;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_search;
    logic [vstk_pkg::VALUE_W-1:0]  w_head;

    // Chain of cells; the first cell is the top of the stack.
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == 0) begin : g_top
            assign w_above_value[j] = i_value;
            assign w_above_occ[j]   = 1'b1;
        end else begin : g_mid
            assign w_above_value[j] = w_value[j-1];
            assign w_above_occ[j]   = w_occ[j-1];
        end
        if (j == DEPTH - 1) begin : g_bottom
            assign w_below_value[j] = '0;
            assign w_below_occ[j]   = 1'b0;
            assign w_below_span[j]  = 1'b0;
        end else begin : g_inner
            assign w_below_value[j] = w_value[j+1];
            assign w_below_occ[j]   = w_occ[j+1];
            assign w_below_span[j]  = w_span[j+1];
        end

        vstk_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_above_value (w_above_value[j]),
            .i_above_occ   (w_above_occ[j]),
            .i_below_value (w_below_value[j]),
            .i_below_occ   (w_below_occ[j]),
            .i_below_span  (w_below_span[j]),
            .o_value       (w_value[j]),
            .o_occ         (w_occ[j]),
            .o_span        (w_span[j])
        );
    end

    assign w_head     = w_value[0];
    assign w_full     = w_occ[DEPTH-1];
    assign w_empty    = (r_count == '0);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_search   = (r_cmd == vstk_pkg::CMD_REMOVE) ||
                        ((r_cmd == vstk_pkg::CMD_EXTRACT) && r_pass2);
    assign w_out_load = (r_state == ST_RESULT) && (!r_out_valid || !i_out_stall);

    // Sequencer: starts each command and steps the rotations past the top cell.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_max       = r_max;
        n_res       = r_res;
        n_stat      = r_stat;
        n_found     = r_found;
        n_pass2     = r_pass2;
        n_count     = r_count;
        n_steps     = r_steps;
        w_ctl.op    = vstk_pkg::CELL_HOLD;
        w_ctl.head  = w_head;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd   = vstk_pkg::t_cmd'(i_command);
                    n_key   = i_value;
                    n_max   = '0;
                    n_res   = '0;
                    n_stat  = vstk_pkg::STAT_OK;
                    n_found = 1'b0;
                    n_pass2 = 1'b0;
                    n_state = ST_RESULT;
                    case (vstk_pkg::t_cmd'(i_command))
                        vstk_pkg::CMD_PUSH: begin
                            if (w_full) begin
                                n_stat = vstk_pkg::STAT_FULL;
                            end else begin
                                w_ctl.op = vstk_pkg::CELL_PUSH;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        vstk_pkg::CMD_POP: begin
                            if (w_empty) begin
                                n_stat = vstk_pkg::STAT_EMPTY;
                            end else begin
                                w_ctl.op = vstk_pkg::CELL_UP;
                                n_res    = w_head;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        vstk_pkg::CMD_REMOVE, vstk_pkg::CMD_MAX, vstk_pkg::CMD_EXTRACT: begin
                            if (w_empty) begin
                                n_stat = vstk_pkg::STAT_EMPTY;
                            end else begin
                                w_ctl.op = vstk_pkg::CELL_LOAD_SPAN;
                                n_steps  = r_count;
                                n_state  = ST_SCAN;
                            end
                        end
                        vstk_pkg::CMD_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                w_ctl.op = vstk_pkg::CELL_LOAD_SPAN;
                                n_steps  = r_count - CW'(1);
                                n_state  = ST_REV;
                            end
                        end
                        vstk_pkg::CMD_CLEAR: begin
                            w_ctl.op = vstk_pkg::CELL_CLEAR;
                            n_count  = '0;
                        end
                        default: begin
                            n_stat = vstk_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_steps = r_steps - CW'(1);
                // The first match drops the head word; otherwise the head moves to the tail.
                if (w_search) begin
                    if (!r_found && (w_head == r_key)) begin
                        w_ctl.op = vstk_pkg::CELL_UP;
                        n_found  = 1'b1;
                        n_count  = r_count - CW'(1);
                    end else begin
                        w_ctl.op = vstk_pkg::CELL_ROTATE;
                    end
                end else begin
                    w_ctl.op = vstk_pkg::CELL_ROTATE;
                    if (w_head > r_max) begin
                        n_max = w_head;
                    end
                end
                // After a whole turn the words are back in their original order.
                if (r_steps == CW'(1)) begin
                    if ((r_cmd == vstk_pkg::CMD_EXTRACT) && !r_pass2) begin
                        n_pass2 = 1'b1;
                        n_key   = n_max;
                        n_steps = r_count;
                    end else begin
                        n_state = ST_RESULT;
                        case (r_cmd)
                            vstk_pkg::CMD_MAX: begin
                                n_res = n_max;
                            end
                            vstk_pkg::CMD_EXTRACT: begin
                                n_res = r_key;
                            end
                            default: begin
                                n_stat = n_found ? vstk_pkg::STAT_OK : vstk_pkg::STAT_MISSING;
                            end
                        endcase
                    end
                end
            end
            ST_REV: begin
                // Each step moves the head to the end of a span that shrinks by one.
                w_ctl.op = vstk_pkg::CELL_ROT_SHRINK;
                n_steps  = r_steps - CW'(1);
                if (r_steps == CW'(1)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on a load, cleared when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_max   <= n_max;
        r_res   <= n_res;
        r_stat  <= n_stat;
        r_found <= n_found;
        r_pass2 <= n_pass2;
        r_steps <= n_steps;
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value  <= r_res;
            r_out_status <= r_stat;
            r_out_count  <= r_count;
            r_out_empty  <= w_empty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = r_out_empty;

    // The fill count always equals the number of occupied cells.
    `ASSERT_IMPLIES(a_count_matches_cells, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(w_occ)), "fill count disagrees with occupied cells")
    // Occupied cells form an unbroken run from the top of the chain.
    `ASSERT_IMPLIES(a_occ_contiguous, i_clk, i_rst_n, 1'b1, ((w_occ >> 1) & ~w_occ) == '0, "gap in occupied cells")
    // An accepted push onto a stack with room grows it by one.
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_accept && (i_command == vstk_pkg::CMD_PUSH) && !w_full, r_count == $past(r_count) + CW'(1), "push did not grow the stack")
    // A rotation pass never runs with its step counter exhausted.
    `ASSERT_IMPLIES(a_steps_live, i_clk, i_rst_n, (r_state == ST_SCAN) || (r_state == ST_REV), r_steps != '0, "rotation pass with no steps left")

endmodule
